// File: sv/set_assoc_lru_tag_store_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU tag store
// Concurrent checks on the rising clock edge, disabled while reset is low.
// The synthesis branch leaves every macro empty.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_TAG_STORE_MACROS_SVH
`define SET_ASSOC_LRU_TAG_STORE_MACROS_SVH
`ifndef SYNTHESIS
// ante |-> cons, same cycle
`define SALRU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// ante |=> cons, next cycle
`define SALRU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define SALRU_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SALRU_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared constants, codes and types of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package salru_pkg;

	localparam int ADDR_W          = 32;

	localparam int DEF_SETS        = 64;
	localparam int DEF_WAYS        = 8;
	localparam int DEF_LINE_BYTES  = 64;
	localparam int DEF_ADDR_BITS   = 32;

	// command codes
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_INVAL  = 2'd2;

	// access kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;
	localparam logic [1:0] KIND_WB    = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} salru_state_t;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic              writeback_needed;
		logic [ADDR_W-1:0] victim_address;
		logic              invalidated_dirty;
	} salru_res_t;

endpackage

// File: sv/salru_row_update.sv
// ----------------------------------------------------------------------------
// salru_row_update
// Read-modify-write logic for one set: tag match, victim choice, dirty and
// valid update and recency reorder. Purely combinational.
// ----------------------------------------------------------------------------
module salru_row_update #(
	parameter int SETS       = salru_pkg::DEF_SETS,
	parameter int WAYS       = salru_pkg::DEF_WAYS,
	parameter int LINE_BYTES = salru_pkg::DEF_LINE_BYTES,
	parameter int ADDR_BITS  = salru_pkg::DEF_ADDR_BITS,
	localparam int OFF_BITS  = $clog2(LINE_BYTES),
	localparam int SET_BITS  = $clog2(SETS),
	localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1,
	localparam int WAY_W     = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1,
	localparam int EFF_BITS  = (ADDR_BITS < salru_pkg::ADDR_W) ? ADDR_BITS : salru_pkg::ADDR_W,
	localparam int TAG_BITS  = EFF_BITS - OFF_BITS - SET_BITS,
	localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1
) (
	input  logic [1:0]            cmd,
	input  logic [1:0]            kind,
	input  logic [TAG_W-1:0]      tag,
	input  logic [SET_W-1:0]      set_idx,
	input  logic [WAYS-1:0]       valid_in,
	input  logic [WAYS-1:0]       dirty_in,
	input  logic [WAYS*WAY_W-1:0] order_in,
	input  logic [WAYS*TAG_W-1:0] tags_in,
	output logic [WAYS-1:0]       valid_out,
	output logic [WAYS-1:0]       dirty_out,
	output logic [WAYS*WAY_W-1:0] order_out,
	output logic [WAYS*TAG_W-1:0] tags_out,
	output logic                  tag_we,
	output salru_pkg::salru_res_t res
);

	logic [WAY_W-1:0] ord [WAYS];
	logic [TAG_W-1:0] tg  [WAYS];
	logic [WAYS-1:0]  match;
	logic             hit_any;
	logic [WAY_W-1:0] hit_way;
	logic             free_any;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] tgt;
	logic             do_mru;
	logic [WAY_W-1:0] pos;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ord[w]   = order_in[w*WAY_W +: WAY_W];
			tg[w]    = tags_in[w*TAG_W +: TAG_W];
			match[w] = valid_in[w] && (tg[w] == tag);
		end
	end

	// lowest matching way and lowest free way
	always_comb begin
		hit_any  = |match;
		free_any = ~&valid_in;
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w])
				hit_way = WAY_W'(w);
			if (!valid_in[w])
				free_way = WAY_W'(w);
		end
	end

	assign lru_way = ord[WAYS-1];

	always_comb begin
		res       = '0;
		valid_out = valid_in;
		dirty_out = dirty_in;
		tags_out  = tags_in;
		tag_we    = 1'b0;
		do_mru    = 1'b0;
		tgt       = hit_way;
		case (cmd)
			salru_pkg::CMD_LOOKUP: begin
				if (hit_any) begin
					res.hit = 1'b1;
					if (kind == salru_pkg::KIND_WRITE)
						dirty_out[hit_way] = 1'b1;
					do_mru = 1'b1;
				end
			end
			salru_pkg::CMD_FILL: begin
				if (kind == salru_pkg::KIND_WB && hit_any) begin
					// write-back onto a resident line: dirty only, recency kept
					res.hit            = 1'b1;
					dirty_out[hit_way] = 1'b1;
				end else begin
					tgt = free_any ? free_way : lru_way;
					if (!free_any) begin
						res.evicted          = 1'b1;
						res.writeback_needed = dirty_in[lru_way];
						res.victim_address   = ((salru_pkg::ADDR_W'(tg[lru_way]) << SET_BITS)
							| salru_pkg::ADDR_W'(set_idx)) << OFF_BITS;
					end
					valid_out[tgt] = 1'b1;
					dirty_out[tgt] = (kind == salru_pkg::KIND_WRITE) || (kind == salru_pkg::KIND_WB);
					tags_out[tgt*TAG_W +: TAG_W] = tag;
					tag_we = 1'b1;
					do_mru = 1'b1;
				end
			end
			salru_pkg::CMD_INVAL: begin
				if (hit_any) begin
					res.hit               = 1'b1;
					res.invalidated_dirty = dirty_in[hit_way];
					valid_out[hit_way]    = 1'b0;
					dirty_out[hit_way]    = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// move tgt to the front, shifting the entries ahead of its old place down one
	always_comb begin
		pos = WAY_W'(WAYS - 1);
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (ord[i] == tgt)
				pos = WAY_W'(i);
		end
		order_out = order_in;
		if (do_mru) begin
			order_out[0 +: WAY_W] = tgt;
			for (int i = 1; i < WAYS; i++) begin
				if (WAY_W'(i) <= pos)
					order_out[i*WAY_W +: WAY_W] = ord[i-1];
			end
		end
	end

endmodule

// File: sv/set_assoc_lru_tag_store.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store
// Tag store of a set-associative write-back cache with true LRU replacement.
// ----------------------------------------------------------------------------
// In each transaction the edge that accepts start reads the set's row from the
// tag and state memories, and the next edge writes the updated row back and
// registers the result, so done is high for a single cycle once the row is
// written back. busy is high for the cycle after acceptance, so a new
// transaction is taken only after the last one has written back; the write
// lands before the next read, so consecutive transactions to the same set need
// no forwarding. Results have no back-pressure: the receiver must take each
// one in the cycle that done is high. After reset a clearing pass writes every
// set's valid, dirty and recency state, one set per cycle, with busy high
// throughout. SETS and LINE_BYTES must be powers of two.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_tag_store_macros.svh"

module set_assoc_lru_tag_store #(
	parameter int SETS       = salru_pkg::DEF_SETS,
	parameter int WAYS       = salru_pkg::DEF_WAYS,
	parameter int LINE_BYTES = salru_pkg::DEF_LINE_BYTES,
	parameter int ADDR_BITS  = salru_pkg::DEF_ADDR_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   cmd,
	input  logic [1:0]                   kind,
	input  logic [salru_pkg::ADDR_W-1:0] address,
	output logic                         busy,
	output logic                         done,
	output logic                         hit,
	output logic                         evicted,
	output logic                         writeback_needed,
	output logic [salru_pkg::ADDR_W-1:0] victim_address,
	output logic                         invalidated_dirty
);

	localparam int ADDR_W   = salru_pkg::ADDR_W;
	localparam int OFF_BITS = $clog2(LINE_BYTES);
	localparam int SET_BITS = $clog2(SETS);
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int WAY_W    = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;
	localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_BITS = EFF_BITS - OFF_BITS - SET_BITS;
	localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam int ORD_W    = WAYS * WAY_W;
	localparam int META_W   = 2 * WAYS + ORD_W;
	localparam int TROW_W   = WAYS * TAG_W;

	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);
	localparam logic [SET_W-1:0]  SET_MASK  = SET_W'(SETS - 1);
	localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(SETS - 1);

	// row layout: {order, dirty, valid}
	logic [META_W-1:0] meta_mem [SETS];
	logic [TROW_W-1:0] tag_mem  [SETS];

	salru_pkg::salru_state_t state_q, state_d;
	logic [SET_W-1:0]  clr_q, clr_d;

	logic [ADDR_W-1:0] addr_m;
	logic [ADDR_W-1:0] block;
	logic [SET_W-1:0]  set_in;
	logic [TAG_W-1:0]  tag_in;
	logic              accept;

	logic [1:0]        cmd_s1;
	logic [1:0]        kind_s1;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [META_W-1:0] meta_s1;
	logic [TROW_W-1:0] tags_s1;

	logic [ORD_W-1:0]  rst_order;
	logic              meta_we;
	logic [SET_W-1:0]  meta_waddr;
	logic [META_W-1:0] meta_wdata;
	logic              tag_we;

	logic [WAYS-1:0]       upd_valid;
	logic [WAYS-1:0]       upd_dirty;
	logic [ORD_W-1:0]      upd_order;
	logic [TROW_W-1:0]     upd_tags;
	logic                  upd_tag_we;
	salru_pkg::salru_res_t upd_res;
	salru_pkg::salru_res_t res_q;
	logic                  done_q;

	// address split
	assign addr_m = address & ADDR_MASK;
	assign block  = addr_m >> OFF_BITS;
	assign set_in = SET_W'(block) & SET_MASK;
	assign tag_in = TAG_W'(block >> SET_BITS);

	assign busy   = (state_q != salru_pkg::ST_IDLE);
	assign accept = start && (state_q == salru_pkg::ST_IDLE);

	always_comb begin
		for (int w = 0; w < WAYS; w++)
			rst_order[w*WAY_W +: WAY_W] = WAY_W'(w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salru_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		meta_we    = 1'b0;
		meta_waddr = set_s1;
		meta_wdata = {upd_order, upd_dirty, upd_valid};
		tag_we     = 1'b0;
		case (state_q)
			salru_pkg::ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = {rst_order, {WAYS{1'b0}}, {WAYS{1'b0}}};
				if (clr_q == SET_LAST)
					state_d = salru_pkg::ST_IDLE;
				else
					clr_d = clr_q + 1'b1;
			end
			salru_pkg::ST_IDLE: begin
				if (start)
					state_d = salru_pkg::ST_UPDATE;
			end
			salru_pkg::ST_UPDATE: begin
				meta_we = 1'b1;
				tag_we  = upd_tag_we;
				state_d = salru_pkg::ST_IDLE;
			end
			default: state_d = salru_pkg::ST_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_waddr] <= meta_wdata;
		if (accept)
			meta_s1 <= meta_mem[set_in];
	end

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[set_s1] <= upd_tags;
		if (accept)
			tags_s1 <= tag_mem[set_in];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			kind_s1 <= kind;
			set_s1  <= set_in;
			tag_s1  <= tag_in;
		end
	end

	salru_row_update #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.LINE_BYTES (LINE_BYTES),
		.ADDR_BITS  (ADDR_BITS)
	) u_row_update (
		.cmd       (cmd_s1),
		.kind      (kind_s1),
		.tag       (tag_s1),
		.set_idx   (set_s1),
		.valid_in  (meta_s1[0 +: WAYS]),
		.dirty_in  (meta_s1[WAYS +: WAYS]),
		.order_in  (meta_s1[2*WAYS +: ORD_W]),
		.tags_in   (tags_s1),
		.valid_out (upd_valid),
		.dirty_out (upd_dirty),
		.order_out (upd_order),
		.tags_out  (upd_tags),
		.tag_we    (upd_tag_we),
		.res       (upd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == salru_pkg::ST_UPDATE);
	end

	always_ff @(posedge clk) begin
		if (state_q == salru_pkg::ST_UPDATE)
			res_q <= upd_res;
	end

	assign done              = done_q;
	assign hit               = res_q.hit;
	assign evicted           = res_q.evicted;
	assign writeback_needed  = res_q.writeback_needed;
	assign victim_address    = res_q.victim_address;
	assign invalidated_dirty = res_q.invalidated_dirty;

	`SALRU_ASSERT_NXT(a_accept_update, clk, arst_n, accept, state_q == salru_pkg::ST_UPDATE)
	`SALRU_ASSERT_NXT(a_update_done, clk, arst_n, state_q == salru_pkg::ST_UPDATE, done && !busy)
	`SALRU_ASSERT_IMP(a_evict_no_hit, clk, arst_n, done && evicted, !hit && !invalidated_dirty)
	`SALRU_ASSERT_IMP(a_wb_needs_evict, clk, arst_n, done && writeback_needed, evicted)

endmodule

// File: sim/tb_set_assoc_lru_tag_store.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_tag_store
// Self-checking bench for the set-associative LRU tag store. Commands go in
// one transaction at a time. A behavioural copy of the tag, valid, dirty and
// recency state predicts every result, and each done strobe is checked field
// by field against the oldest prediction. Directed cases come first, then
// random traffic aimed at a few hot sets so that hits, evictions and
// write-backs are frequent.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_tag_store;

	localparam int ADDR_W = salru_pkg::ADDR_W;
	localparam int N_SETS = salru_pkg::DEF_SETS;
	localparam int N_WAYS = salru_pkg::DEF_WAYS;
	localparam int OFF_W  = $clog2(salru_pkg::DEF_LINE_BYTES);
	localparam int IDX_W  = $clog2(N_SETS);
	localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
	localparam int WAY_W  = $clog2(N_WAYS);

	// unused command code, must be ignored
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        cmd = salru_pkg::CMD_LOOKUP;
	logic [1:0]        kind = salru_pkg::KIND_READ;
	logic [ADDR_W-1:0] address = '0;
	logic              busy;
	logic              done;
	logic              hit;
	logic              evicted;
	logic              writeback_needed;
	logic [ADDR_W-1:0] victim_address;
	logic              invalidated_dirty;

	set_assoc_lru_tag_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.kind(kind),
		.address(address),
		.busy(busy),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.writeback_needed(writeback_needed),
		.victim_address(victim_address),
		.invalidated_dirty(invalidated_dirty)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("set_assoc_lru_tag_store: mismatch");
		$finish;
	end

	// predicted copy of the tag store
	bit               valid_map   [N_SETS][N_WAYS];
	bit               dirty_map   [N_SETS][N_WAYS];
	logic [TAG_W-1:0] tag_map     [N_SETS][N_WAYS];
	logic [WAY_W-1:0] recency_map [N_SETS][N_WAYS];	// MRU first

	salru_pkg::salru_res_t pending_outcomes[$];

	int errors = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_hits = 0;
	int n_evictions = 0;
	int n_writebacks = 0;
	int n_inval_dirty = 0;

	bit              no_gaps = 1'b0;
	logic [IDX_W-1:0] hot_sets[4];
	logic [TAG_W-1:0] tag_pool[12];

	function automatic void clear_store();
		for (int s = 0; s < N_SETS; s++)
			for (int w = 0; w < N_WAYS; w++) begin
				valid_map[s][w]   = 1'b0;
				dirty_map[s][w]   = 1'b0;
				tag_map[s][w]     = '0;
				recency_map[s][w] = WAY_W'(w);
			end
	endfunction

	function automatic int lowest_match(logic [IDX_W-1:0] s, logic [TAG_W-1:0] t);
		for (int w = 0; w < N_WAYS; w++)
			if (valid_map[s][w] && tag_map[s][w] == t)
				return w;
		return -1;
	endfunction

	function automatic void promote(logic [IDX_W-1:0] s, int w);
		int pos;
		pos = N_WAYS - 1;
		for (int i = N_WAYS - 1; i >= 0; i--)
			if (recency_map[s][i] == WAY_W'(w))
				pos = i;
		for (int i = pos; i > 0; i--)
			recency_map[s][i] = recency_map[s][i-1];
		recency_map[s][0] = WAY_W'(w);
	endfunction

	function automatic salru_pkg::salru_res_t tag_store_access(logic [1:0] c, logic [1:0] k,
			logic [ADDR_W-1:0] a);
		salru_pkg::salru_res_t r;
		logic [IDX_W-1:0]      s;
		logic [TAG_W-1:0]      t;
		int                    w;
		r = '0;
		s = a[OFF_W +: IDX_W];
		t = a[ADDR_W-1 -: TAG_W];
		case (c)
			salru_pkg::CMD_LOOKUP: begin
				w = lowest_match(s, t);
				if (w >= 0) begin
					if (k == salru_pkg::KIND_WRITE)
						dirty_map[s][w] = 1'b1;
					promote(s, w);
					r.hit = 1'b1;
				end
			end
			salru_pkg::CMD_FILL: begin
				w = (k == salru_pkg::KIND_WB) ? lowest_match(s, t) : -1;
				if (w >= 0) begin
					// write-back onto a resident line: dirty only, recency untouched
					dirty_map[s][w] = 1'b1;
					r.hit = 1'b1;
				end else begin
					for (int i = N_WAYS - 1; i >= 0; i--)
						if (!valid_map[s][i])
							w = i;
					if (w < 0) begin
						w = int'(recency_map[s][N_WAYS-1]);
						r.evicted          = 1'b1;
						r.writeback_needed = dirty_map[s][w];
						r.victim_address   = {tag_map[s][w], s, {OFF_W{1'b0}}};
					end
					valid_map[s][w] = 1'b1;
					tag_map[s][w]   = t;
					dirty_map[s][w] = (k == salru_pkg::KIND_WRITE) || (k == salru_pkg::KIND_WB);
					promote(s, w);
				end
			end
			salru_pkg::CMD_INVAL: begin
				w = lowest_match(s, t);
				if (w >= 0) begin
					r.hit               = 1'b1;
					r.invalidated_dirty = dirty_map[s][w];
					valid_map[s][w]     = 1'b0;
					dirty_map[s][w]     = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result check, then prediction of any transaction taken at this edge
	always @(posedge clk) begin : check_and_predict
		salru_pkg::salru_res_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				n_checked++;
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					errors++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, evicted);
					errors++;
				end
				if (writeback_needed !== want.writeback_needed) begin
					$error("writeback_needed: expected %0d, got %0d",
						want.writeback_needed, writeback_needed);
					errors++;
				end
				if (victim_address !== want.victim_address) begin
					$error("victim_address: expected %h, got %h",
						want.victim_address, victim_address);
					errors++;
				end
				if (invalidated_dirty !== want.invalidated_dirty) begin
					$error("invalidated_dirty: expected %0d, got %0d",
						want.invalidated_dirty, invalidated_dirty);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			want = tag_store_access(cmd, kind, address);
			pending_outcomes = {pending_outcomes, want};
			n_accepted++;
			n_hits        += want.hit;
			n_evictions   += want.evicted;
			n_writebacks  += want.writeback_needed;
			n_inval_dirty += want.invalidated_dirty;
		end
	end

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// start stays high across back-to-back transactions
	task automatic send_item(logic [1:0] c, logic [1:0] k, logic [ADDR_W-1:0] a);
		int gap;
		start   <= 1'b1;
		cmd     <= c;
		kind    <= k;
		address <= a;
		do
			@(posedge clk);
		while (busy);
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] t,
			logic [IDX_W-1:0] s);
		return {t, s, {OFF_W{1'b0}}};
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address(bit one_set);
		logic [IDX_W-1:0] s;
		logic [OFF_W-1:0] off;
		off = OFF_W'($urandom);
		if (!one_set && $urandom_range(0, 9) == 0)
			return ADDR_W'($urandom);
		s = one_set ? hot_sets[0] : hot_sets[$urandom_range(0, 3)];
		return {tag_pool[$urandom_range(0, 11)], s, off};
	endfunction

	function automatic logic [1:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return salru_pkg::CMD_LOOKUP;
		if (r < 80)
			return salru_pkg::CMD_FILL;
		if (r < 95)
			return salru_pkg::CMD_INVAL;
		return CMD_UNUSED;
	endfunction

	task automatic test_directed_basics();
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_READ, '0);	// miss on empty store
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_READ, '0);
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_READ, 32'h0000_003F);
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_WB, '0);	// not a write, stays clean
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_WRITE, '0);
		send_item(salru_pkg::CMD_INVAL, salru_pkg::KIND_FETCH, '0);	// dirty line dropped
		send_item(salru_pkg::CMD_INVAL, salru_pkg::KIND_READ, '0);
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_FETCH, '1);
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_FETCH, '1);
		send_item(CMD_UNUSED, salru_pkg::KIND_WRITE, '1);
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_READ, '1);
	endtask

	task automatic test_set_eviction();
		logic [IDX_W-1:0] s;
		s = IDX_W'(5);
		for (int w = 0; w < N_WAYS; w++)
			send_item(salru_pkg::CMD_FILL,
				(w == 0 || w == 4) ? salru_pkg::KIND_WRITE : salru_pkg::KIND_READ,
				line_addr(TAG_W'(32'h100 + w), s));
		// dirty victim
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_READ, line_addr(TAG_W'(32'h200), s));
		// write-back hit
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_WB, line_addr(TAG_W'(32'h103), s));
		// write-back miss
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_WB, line_addr(TAG_W'(32'h201), s));
		// duplicate
		send_item(salru_pkg::CMD_FILL, salru_pkg::KIND_FETCH, line_addr(TAG_W'(32'h200), s));
		send_item(salru_pkg::CMD_LOOKUP, salru_pkg::KIND_READ, line_addr(TAG_W'(32'h200), s));
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (60)
			send_item(pick_cmd(), 2'($urandom), pick_address(1'b1));
		no_gaps = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 1440; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_item(pick_cmd(), 2'($urandom), pick_address(1'b0));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		clear_store();
		hot_sets[0] = '0;
		hot_sets[1] = '1;
		hot_sets[2] = IDX_W'($urandom);
		hot_sets[3] = IDX_W'($urandom);
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			tag_pool[i] = TAG_W'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_basics();
		test_set_eviction();
		test_back_to_back();
		test_random_traffic();
		start <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d transactions, %0d results checked: %0d hits, %0d evictions",
			n_accepted, n_checked, n_hits, n_evictions);
		$display("%0d dirty victims, %0d dirty lines invalidated",
			n_writebacks, n_inval_dirty);
		if (errors == 0)
			$display("set_assoc_lru_tag_store: match");
		else
			$display("set_assoc_lru_tag_store: mismatch");
		$finish;
	end

endmodule
